// ===== src/kdt_pkg.sv =====
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types, constants and helper functions for the keypad tone transmitter.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int CFG_W        = 24;
    localparam int CODE_W       = 4;
    localparam int CHAR_W       = 7;
    localparam int DRIVE_W      = 4;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam int KEY_ROWS_DEF  = 4;
    localparam int CODE_BITS_DEF = 4;

    localparam logic [CFG_W-1:0] TONE_ONE_RST = 24'd125000;
    localparam logic [CFG_W-1:0] TONE_TWO_RST = 24'd41667;
    localparam logic [CFG_W-1:0] BIT_PER_RST  = 24'd6000000;
    localparam logic [CFG_W-1:0] HOLDOFF_RST  = 24'd40000;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

    // Register indexes on the APB port.
    localparam logic [1:0] REG_TONE_ONE = 2'd0;
    localparam logic [1:0] REG_TONE_TWO = 2'd1;
    localparam logic [1:0] REG_BIT_PER  = 2'd2;
    localparam logic [1:0] REG_HOLDOFF  = 2'd3;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_SEND,
        PH_RELEASE,
        PH_HOLD
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] tone_one_half;
        logic [CFG_W-1:0] tone_two_half;
        logic [CFG_W-1:0] bit_period;
        logic [CFG_W-1:0] holdoff;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] row_drive;
        logic               key_valid;
        logic [CODE_W-1:0]  key_code;
        logic [CHAR_W-1:0]  key_char;
        logic               busy;
    } scan_res_t;

    typedef struct packed {
        logic keyed;
        logic carrier;
    } led_t;

    typedef struct packed {
        logic             fire;
        logic [CFG_W-1:0] count;
    } tick_t;

    // Advance a tick counter; wrap to zero and fire once the limit is reached.
    function automatic tick_t tick_step(input logic [CFG_W-1:0] count,
                                        input logic [CFG_W-1:0] limit);
        logic [CFG_W:0]   sum;
        logic [CFG_W-1:0] n;
        tick_t            r;
        sum = {1'b0, count} + {{CFG_W{1'b0}}, 1'b1};
        n   = sum[CFG_W-1:0];
        if ((n >= limit) || (n == '0))
        begin
            r.fire  = 1'b1;
            r.count = '0;
        end
        else
        begin
            r.fire  = 1'b0;
            r.count = n;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        c = {{(CHAR_W-CODE_W){1'b0}}, code};
        if (code < CODE_W'(10))
            return ASCII_ZERO + c;
        else
            return ASCII_A + c - CHAR_W'(10);
    endfunction

endpackage

// ===== src/kdt_tones.sv =====
// ----------------------------------------------------------------------------
// kdt_tones
// Tone one and tone two counters with the keyed and carrier LED levels.
// ----------------------------------------------------------------------------
module kdt_tones (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      keying_on,
    input  kdt_pkg::cfg_t             cfg,
    output kdt_pkg::led_t             leds_next
);
    import kdt_pkg::*;

    logic [CFG_W-1:0] one_cnt_reg;
    logic [CFG_W-1:0] two_cnt_reg;
    logic             keyed_reg;
    logic             carrier_reg;
    tick_t            one_tick;
    tick_t            two_tick;

    always_comb
    begin
        one_tick = tick_step(one_cnt_reg, cfg.tone_one_half);
        two_tick = tick_step(two_cnt_reg, cfg.tone_two_half);
        leds_next.keyed   = keyed_reg;
        leds_next.carrier = carrier_reg;
        if (one_tick.fire)
            leds_next.keyed = keying_on ? ~keyed_reg : 1'b0;
        if (two_tick.fire)
            leds_next.carrier = ~carrier_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_cnt_reg <= '0;
            two_cnt_reg <= '0;
            keyed_reg   <= 1'b0;
            carrier_reg <= 1'b0;
        end
        else if (advance)
        begin
            one_cnt_reg <= one_tick.count;
            two_cnt_reg <= two_tick.count;
            keyed_reg   <= leds_next.keyed;
            carrier_reg <= leds_next.carrier;
        end
    end

endmodule

// ===== src/kdt_scan.sv =====
// ----------------------------------------------------------------------------
// kdt_scan
// Row scan, key detect, bit sequencing, release wait and holdoff.
// ----------------------------------------------------------------------------
module kdt_scan #(
    parameter int KEY_ROWS  = kdt_pkg::KEY_ROWS_DEF,
    parameter int CODE_BITS = kdt_pkg::CODE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [3:0]                  column_sense,
    input  kdt_pkg::cfg_t               cfg,
    output logic                        keying_on,
    output kdt_pkg::scan_res_t          res
);
    import kdt_pkg::*;

    localparam int RW = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int SW = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    phase_t            phase_reg, phase_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [SW-1:0]     sent_reg, sent_next;
    logic [CFG_W-1:0]  period_reg, period_next;
    logic [CODE_W-1:0] held_reg, held_next;
    logic              keying_reg, keying_next;

    logic [1:0]        top_col;
    logic [RW+5:0]     code_ext;
    logic [CODE_W-1:0] code;
    logic [RW:0]       row_inc;
    logic [RW-1:0]     row_adv;
    logic [SW:0]       sent_inc;
    logic [7:0]        held_shift;
    logic [CFG_W:0]    period_inc;
    tick_t             bit_tick;

    assign keying_on = keying_reg;

    always_comb
    begin
        if (column_sense[3])
            top_col = 2'd3;
        else if (column_sense[2])
            top_col = 2'd2;
        else if (column_sense[1])
            top_col = 2'd1;
        else
            top_col = 2'd0;
        code_ext = {4'b0, row_reg, top_col};
        code     = code_ext[CODE_W-1:0];
        row_inc  = {1'b0, row_reg} + {{RW{1'b0}}, 1'b1};
        row_adv  = (row_inc >= (RW+1)'(KEY_ROWS)) ? '0 : row_inc[RW-1:0];
        sent_inc = {1'b0, sent_reg} + {{SW{1'b0}}, 1'b1};
        held_shift = {4'b0, held_reg} >> sent_inc;
        period_inc = {1'b0, period_reg} + {{CFG_W{1'b0}}, 1'b1};
        bit_tick = tick_step(period_reg, cfg.bit_period);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        sent_next   = sent_reg;
        period_next = period_reg;
        held_next   = held_reg;
        keying_next = keying_reg;
        res.key_valid = 1'b0;
        res.key_code  = '0;
        res.key_char  = '0;
        case (phase_reg)
            PH_SCAN:
            begin
                if (column_sense != 4'd0)
                begin
                    res.key_valid = 1'b1;
                    res.key_code  = code;
                    res.key_char  = hex_char(code);
                    held_next     = code;
                    sent_next     = '0;
                    period_next   = '0;
                    keying_next   = code[0];
                    phase_next    = PH_SEND;
                end
                else
                begin
                    row_next = row_adv;
                end
            end
            PH_SEND:
            begin
                period_next = bit_tick.count;
                if (bit_tick.fire)
                begin
                    if (sent_inc >= (SW+1)'(CODE_BITS))
                    begin
                        keying_next = 1'b0;
                        sent_next   = '0;
                        phase_next  = PH_RELEASE;
                    end
                    else
                    begin
                        sent_next   = sent_inc[SW-1:0];
                        keying_next = held_shift[0];
                    end
                end
            end
            PH_RELEASE:
            begin
                if (column_sense == 4'd0)
                begin
                    period_next = '0;
                    phase_next  = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (period_reg >= cfg.holdoff)
                begin
                    period_next = '0;
                    phase_next  = PH_SCAN;
                    row_next    = row_adv;
                end
                else
                begin
                    period_next = period_inc[CFG_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase
        for (int i = 0; i < DRIVE_W; i++)
            res.row_drive[i] = ({4'b0, row_reg} == (RW+4)'(i));
        res.busy = (phase_next != PH_SCAN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCAN;
            row_reg    <= '0;
            sent_reg   <= '0;
            period_reg <= '0;
            held_reg   <= '0;
            keying_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            sent_reg   <= sent_next;
            period_reg <= period_next;
            held_reg   <= held_next;
            keying_reg <= keying_next;
        end
    end

endmodule

// ===== src/keypad_dual_tone_light_transmitter.sv =====
// ----------------------------------------------------------------------------
// keypad_dual_tone_light_transmitter
// Each accepted beat on the item channel is one timer tick carrying the four
// column lines of the keypad row being driven. The block returns one result
// beat per item: the row driven during that tick, both LED levels after the
// tick, a key report (valid, code, ASCII hex digit) on the tick a press is
// seen, and a busy flag while the key's bits are sent, release is awaited or
// the holdoff runs. An item is taken every clock cycle; the only wait is the
// result register, which holds a beat while result_stall is high, so the
// tick rate is one per cycle whenever the result side keeps up. Results are
// registered the cycle after its item. The user must change the four 24-bit
// timing registers (APB bytes 0, 4, 8, 12) only while idle, unenforced.
// ----------------------------------------------------------------------------
module keypad_dual_tone_light_transmitter #(
    parameter int KEY_ROWS  = kdt_pkg::KEY_ROWS_DEF,
    parameter int CODE_BITS = kdt_pkg::CODE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kdt_pkg::APB_AW-1:0]   paddr,
    input  logic [kdt_pkg::APB_DW-1:0]   pwdata,
    output logic [kdt_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [3:0]                   column_sense,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [kdt_pkg::DRIVE_W-1:0]  row_drive,
    output logic                         keyed_led,
    output logic                         carrier_led,
    output logic                         key_valid,
    output logic [kdt_pkg::CODE_W-1:0]   key_code,
    output logic [kdt_pkg::CHAR_W-1:0]   key_char,
    output logic                         busy_res
);
    import kdt_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] cfg_idx;
    logic       cfg_wr;
    logic       advance;
    logic       keying_on;
    led_t       leds_next;
    scan_res_t  scan_res;
    logic       result_valid_reg, result_valid_next;
    scan_res_t  res_reg;
    led_t       leds_reg;

    // Register file: index is the word address, data kept to 24 bits.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_one_half <= TONE_ONE_RST;
            cfg_reg.tone_two_half <= TONE_TWO_RST;
            cfg_reg.bit_period    <= BIT_PER_RST;
            cfg_reg.holdoff       <= HOLDOFF_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TONE_ONE: cfg_reg.tone_one_half <= pwdata[CFG_W-1:0];
                REG_TONE_TWO: cfg_reg.tone_two_half <= pwdata[CFG_W-1:0];
                REG_BIT_PER:  cfg_reg.bit_period    <= pwdata[CFG_W-1:0];
                REG_HOLDOFF:  cfg_reg.holdoff       <= pwdata[CFG_W-1:0];
                default:      cfg_reg.holdoff       <= cfg_reg.holdoff;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TONE_ONE: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.tone_one_half};
            REG_TONE_TWO: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.tone_two_half};
            REG_BIT_PER:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.bit_period};
            REG_HOLDOFF:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.holdoff};
            default:      prdata = '0;
        endcase
    end

    // Hold the item side only while a finished beat waits at the result.
    assign item_stall = result_valid_reg && result_stall;
    assign advance    = item_valid && !item_stall;

    // Tone counters see keying_on as it stood at the start of the tick.
    kdt_tones u_tones (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .keying_on (keying_on),
        .cfg       (cfg_reg),
        .leds_next (leds_next)
    );

    kdt_scan #(
        .KEY_ROWS  (KEY_ROWS),
        .CODE_BITS (CODE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .column_sense (column_sense),
        .cfg          (cfg_reg),
        .keying_on    (keying_on),
        .res          (scan_res)
    );

    // Result register: load on every accepted tick, drop once taken.
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg  <= scan_res;
            leds_reg <= leds_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign row_drive    = res_reg.row_drive;
    assign keyed_led    = leds_reg.keyed;
    assign carrier_led  = leds_reg.carrier;
    assign key_valid    = res_reg.key_valid;
    assign key_code     = res_reg.key_code;
    assign key_char     = res_reg.key_char;
    assign busy_res     = res_reg.busy;

endmodule
